// ===== sv/rdp_pkg.sv =====
// Shared types and constants for the random draw pool.
// No dependencies; imported by the divider and the top level.
`default_nettype none

package rdp_pkg;

   // Width of one token ID and of the result status
   localparam int ID_W   = 6;
   localparam int STAT_W = 2;

   // Request mode codes
   localparam logic MODE_DRAW   = 1'b0;
   localparam logic MODE_RETURN = 1'b1;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_DRAWN    = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_ACCEPTED = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // Status of the iterative modulo unit
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== sv/rdp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rdp_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rdp_divider.sv =====
// Iterative restoring modulo unit: one dividend bit per cycle.
// Depends on rdp_pkg for the status struct.
`default_nettype none

module rdp_divider
   import rdp_pkg::*;
#(
   parameter int DVD_W = 16,
   parameter int DVS_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output div_status_type        status,
   output logic      [DVS_W-1:0] remainder
);

   localparam int SW = (DVD_W > 1) ? $clog2(DVD_W) : 1;
   localparam logic [SW-1:0] LAST_STEP = SW'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   // Shift in the next dividend bit and subtract where it fits
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
         end else begin
            rem_in = trial[DVS_W-1:0];
         end
         step_in = step_ff + SW'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

// ===== sv/random_draw_pool_with_discard.sv =====
// Top level of the random draw pool with a return pile.
// Depends on rdp_pkg, rdp_ram and rdp_divider.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_mode, req_card_in, req_random_value
//   rsp      out        rsp_valid/rsp_stall  rsp_card_out, rsp_status
//   csr      in/out     APB, pready high     total_cards at byte 0
//
// One item at a time. A return goes from idle straight to the finish state; a draw runs
// the bit-serial modulo unit, then two reads through the single read port of the pool RAM.
// A draw from an empty pool first copies the pile, one entry per cycle.
// After reset and after each total_cards write, a clearing pass writes pool entry i = i,
// one entry per cycle, with req_stall high until the pass is done.
// A result waits in the output register while rsp_stall is high; req_stall stays
// high until the block is back in idle.
`default_nettype none

module random_draw_pool_with_discard
   import rdp_pkg::*;
#(
   parameter int MAX_IDS     = 64,
   parameter int RANDOM_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_mode,
   input  wire logic [ID_W-1:0]        req_card_in,
   input  wire logic [RANDOM_BITS-1:0] req_random_value,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [ID_W-1:0]        rsp_card_out,
   output logic      [STAT_W-1:0]      rsp_status,
   // configuration port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [2:0]             csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic      [31:0]            csr_prdata,
   output logic                        csr_pready
);

   localparam int CNT_W = $clog2(MAX_IDS + 1);
   localparam int AW    = $clog2(MAX_IDS);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DIV,
      S_REFILL,
      S_REFILL_END,
      S_RD_PICK,
      S_RD_LAST,
      S_WR,
      S_FIN
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     pool_count_ff, pool_count_in;
   logic [CNT_W-1:0]     pile_count_ff, pile_count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 copy_vld_ff, copy_vld_in;
   logic [CNT_W-1:0]     copy_idx_ff, copy_idx_in;
   logic [RANDOM_BITS-1:0] rnd_ff, rnd_in;
   logic [CNT_W-1:0]     pick_ff, pick_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [ID_W-1:0]      res_card_ff, res_card_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_card_ff, rsp_card_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 csr_wr;
   logic [31:0]          cfg_value;
   logic [CNT_W-1:0]     cfg_total;
   logic                 req_xfer;
   logic                 slot_free;
   logic [CNT_W:0]       held_sum;
   logic [CNT_W-1:0]     last_idx;

   logic                 pool_we;
   logic [AW-1:0]        pool_waddr;
   logic [ID_W-1:0]      pool_wdata;
   logic [AW-1:0]        pool_raddr;
   logic [ID_W-1:0]      pool_rdata;
   logic                 pile_we;
   logic [ID_W-1:0]      pile_rdata;

   logic                 div_start;
   logic [CNT_W-1:0]     div_dvs;
   div_status_type       div_stat;
   logic [CNT_W-1:0]     div_rem;

   // Decode the register write and saturate the total to the pool depth
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign cfg_value  = {25'd0, csr_pwdata[6:0]};
   assign cfg_total  = (cfg_value > 32'(MAX_IDS)) ? CNT_W'(MAX_IDS) : CNT_W'(cfg_value);
   assign csr_prdata = 32'(total_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign held_sum  = {1'b0, pool_count_ff} + {1'b0, pile_count_ff};
   assign last_idx  = pool_count_ff - CNT_W'(1);

   // Next state and datapath values
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      pool_count_in = pool_count_ff;
      pile_count_in = pile_count_ff;
      idx_in        = idx_ff;
      copy_vld_in   = 1'b0;
      copy_idx_in   = idx_ff;
      rnd_in        = rnd_ff;
      pick_in       = pick_ff;
      id_in         = id_ff;
      res_card_in   = res_card_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_card_in   = rsp_card_ff;
      rsp_status_in = rsp_status_ff;
      pool_we       = 1'b0;
      pool_waddr    = AW'(pick_ff);
      pool_wdata    = pile_rdata;
      pool_raddr    = AW'(pick_ff);
      pile_we       = 1'b0;
      div_start     = 1'b0;
      div_dvs       = pool_count_ff;

      // Land the pile word read in the previous cycle
      if (copy_vld_ff) begin
         pool_we    = 1'b1;
         pool_waddr = AW'(copy_idx_ff);
         pool_wdata = pile_rdata;
      end

      unique case (state_ff)
         S_INIT: begin
            if (idx_ff == total_ff) begin
               state_in = S_IDLE;
            end else begin
               pool_we    = 1'b1;
               pool_waddr = AW'(idx_ff);
               pool_wdata = ID_W'(idx_ff);
               idx_in     = idx_ff + CNT_W'(1);
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               rnd_in      = req_random_value;
               res_card_in = '0;
               if (req_mode == MODE_RETURN) begin
                  state_in = S_FIN;
                  if (held_sum >= {1'b0, total_ff}) begin
                     res_status_in = ST_FULL;
                  end else begin
                     pile_we       = 1'b1;
                     pile_count_in = pile_count_ff + CNT_W'(1);
                     res_status_in = ST_ACCEPTED;
                  end
               end else if (pool_count_ff != '0) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else if (pile_count_ff != '0) begin
                  idx_in   = '0;
                  state_in = S_REFILL;
               end else begin
                  res_status_in = ST_EMPTY;
                  state_in      = S_FIN;
               end
            end
         end
         S_REFILL: begin
            copy_vld_in = 1'b1;
            copy_idx_in = idx_ff;
            idx_in      = idx_ff + CNT_W'(1);
            if (idx_ff == pile_count_ff - CNT_W'(1)) begin
               state_in = S_REFILL_END;
            end
         end
         S_REFILL_END: begin
            pool_count_in = pile_count_ff;
            pile_count_in = '0;
            div_dvs       = pile_count_ff;
            div_start     = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               pick_in  = div_rem;
               state_in = S_RD_PICK;
            end
         end
         S_RD_PICK: begin
            pool_raddr = AW'(pick_ff);
            state_in   = S_RD_LAST;
         end
         S_RD_LAST: begin
            pool_raddr = AW'(last_idx);
            id_in      = pool_rdata;
            state_in   = S_WR;
         end
         S_WR: begin
            // Move the last pool entry into the gap
            pool_we       = 1'b1;
            pool_waddr    = AW'(pick_ff);
            pool_wdata    = pool_rdata;
            pool_count_in = last_idx;
            res_card_in   = id_ff;
            res_status_in = ST_DRAWN;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_card_in   = res_card_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Reinitialize on a total write
      if (csr_wr) begin
         total_in      = cfg_total;
         pool_count_in = cfg_total;
         pile_count_in = '0;
         idx_in        = '0;
         copy_vld_in   = 1'b0;
         state_in      = S_INIT;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         total_ff      <= CNT_W'(MAX_IDS);
         pool_count_ff <= CNT_W'(MAX_IDS);
         pile_count_ff <= '0;
         idx_ff        <= '0;
         copy_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         pool_count_ff <= pool_count_in;
         pile_count_ff <= pile_count_in;
         idx_ff        <= idx_in;
         copy_vld_ff   <= copy_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      copy_idx_ff   <= copy_idx_in;
      rnd_ff        <= rnd_in;
      pick_ff       <= pick_in;
      id_ff         <= id_in;
      res_card_ff   <= res_card_in;
      res_status_ff <= res_status_in;
      rsp_card_ff   <= rsp_card_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_card_out = rsp_card_ff;
   assign rsp_status   = rsp_status_ff;

   // Pool of IDs still available
   rdp_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_IDS)
   ) u_pool (
      .clock   (clock),
      .wr_en   (pool_we),
      .wr_addr (pool_waddr),
      .wr_data (pool_wdata),
      .rd_addr (pool_raddr),
      .rd_data (pool_rdata)
   );

   // Pile of returned IDs
   rdp_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_IDS)
   ) u_pile (
      .clock   (clock),
      .wr_en   (pile_we),
      .wr_addr (AW'(pile_count_ff)),
      .wr_data (req_card_in),
      .rd_addr (AW'(idx_ff)),
      .rd_data (pile_rdata)
   );

   // Reduce the random value modulo the pool count
   rdp_divider #(
      .DVD_W (RANDOM_BITS),
      .DVS_W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_start && (state_ff == S_IDLE) ? req_random_value : rnd_ff),
      .divisor   (div_dvs),
      .status    (div_stat),
      .remainder (div_rem)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_random_draw_pool_with_discard.sv =====
// Testbench for random_draw_pool_with_discard: directed table, then random phases.
// Depends on rdp_pkg and the block's RTL. Checks every result against the table's expected value or a local pool model.
`default_nettype none

module tb_random_draw_pool_with_discard;
   import rdp_pkg::*;

   localparam int POOL_DEPTH  = 64;
   localparam int RND_W       = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int PRINT_LIMIT = 50;
   localparam logic [2:0] TOTAL_ADDR = 3'd0;

   typedef struct packed {
      logic [ID_W-1:0] card;
      status_type      status;
   } pool_result_type;

   typedef enum {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic             mode;
      logic [ID_W-1:0]  card;
      logic [RND_W-1:0] rnd;
      logic [6:0]       total;
      bit               typed;
      pool_result_type  want;
   } stim_row_type;

   // Clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_mode = MODE_DRAW;
   logic [ID_W-1:0]  req_card_in = '0;
   logic [RND_W-1:0] req_random_value = '0;
   logic             rsp_stall = 1'b0;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [2:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;

   logic              req_stall;
   logic              rsp_valid;
   logic [ID_W-1:0]   rsp_card_out;
   logic [STAT_W-1:0] rsp_status;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // Local copy of the pool and pile
   logic [ID_W-1:0] pool_ids [POOL_DEPTH];
   logic [ID_W-1:0] pile_ids [POOL_DEPTH];
   int pool_n;
   int pile_n;
   int id_total;

   pool_result_type pool_answers [$];
   stim_row_type    directed_rows [$];
   int  fail_count  = 0;
   int  cycle_count = 0;
   int  burst_left  = 1;
   bit  valid_high  = 1'b0;
   int  stall_left  = 0;
   int  stall_style = 0;

   random_draw_pool_with_discard #(
      .MAX_IDS(POOL_DEPTH),
      .RANDOM_BITS(RND_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_card_in(req_card_in),
      .req_random_value(req_random_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_card_out(rsp_card_out),
      .rsp_status(rsp_status),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Saturate the total, refill the pool in order and empty the pile
   function automatic void load_total(input logic [6:0] value);
      id_total = (value > POOL_DEPTH) ? POOL_DEPTH : int'(value);
      for (int i = 0; i < POOL_DEPTH; i++) begin
         pool_ids[i] = ID_W'(i);
      end
      pool_n = id_total;
      pile_n = 0;
   endfunction

   // Advance the pool model by one request and return its answer
   function automatic pool_result_type pool_step(input logic mode,
                                                 input logic [ID_W-1:0] card,
                                                 input logic [RND_W-1:0] rnd);
      pool_result_type res;
      int pick;
      res.card = '0;
      if (mode == MODE_RETURN) begin
         if (pool_n + pile_n >= id_total || pile_n >= POOL_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pile_ids[pile_n] = card;
            pile_n++;
            res.status = ST_ACCEPTED;
         end
         return res;
      end
      if (pool_n == 0) begin
         if (pile_n == 0) begin
            res.status = ST_EMPTY;
            return res;
         end
         // empty pool: move the pile over in order, then draw
         for (int i = 0; i < pile_n; i++) begin
            pool_ids[i] = pile_ids[i];
         end
         pool_n = pile_n;
         pile_n = 0;
      end
      pick = int'(rnd) % pool_n;
      res.card = pool_ids[pick];
      pool_n--;
      pool_ids[pick] = pool_ids[pool_n];
      res.status = ST_DRAWN;
      return res;
   endfunction

   task automatic report(input string field, input int got, input int want);
      if (fail_count < PRINT_LIMIT) begin
         $display("mismatch on %s: got %0d, want %0d (cycle %0d)", field, got, want, cycle_count);
      end
      fail_count++;
   endtask

   task automatic add_item(input logic mode, input logic [ID_W-1:0] card,
                           input logic [RND_W-1:0] rnd, input bit typed,
                           input logic [ID_W-1:0] want_card, input status_type want_status);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.mode = mode;
      row.card = card;
      row.rnd = rnd;
      row.total = '0;
      row.typed = typed;
      row.want.card = want_card;
      row.want.status = want_status;
      directed_rows.push_back(row);
   endtask

   task automatic add_cfg(input logic [6:0] value);
      stim_row_type row;
      row.kind = ROW_CFG;
      row.mode = MODE_DRAW;
      row.card = '0;
      row.rnd = '0;
      row.total = value;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endtask

   // Drop valid and let the drop reach the block so the request channel is quiet
   task automatic release_valid();
      if (valid_high) begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
         @(posedge clock);
      end
   endtask

   // Present one request, hold it until the transfer, then maybe idle
   task automatic send_item(input logic mode, input logic [ID_W-1:0] card,
                            input logic [RND_W-1:0] rnd, input bit typed,
                            input pool_result_type want);
      pool_result_type predicted;
      int gap;
      if (!valid_high) begin
         req_valid <= 1'b1;
         valid_high = 1'b1;
      end
      req_mode <= mode;
      req_card_in <= card;
      req_random_value <= rnd;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = pool_step(mode, card, rnd);
      pool_answers.push_back(typed ? want : predicted);
      // end of burst: pick the next burst length and a gap, sometimes none
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_high = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Write total_cards once the block is idle and nothing is outstanding
   task automatic write_total(input logic [6:0] value);
      release_valid();
      while (pool_answers.size() != 0 || req_stall !== 1'b0) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TOTAL_ADDR;
      csr_pwdata <= {25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      load_total(value);
   endtask

   // Stimulus: directed table, then random phases
   initial begin
      stim_row_type row;
      logic mode;
      logic [6:0] total;
      int n;
      int draw_pct;
      int items_sent;

      load_total(7'd64);

      // full pool after reset: return rejected, edge draws, pile fills to the total
      add_item(MODE_RETURN, 6'd5, 16'd0, 1'b1, 6'd0, ST_FULL);
      add_item(MODE_DRAW, 6'd0, 16'd0, 1'b1, 6'd0, ST_DRAWN);
      add_item(MODE_DRAW, 6'd63, 16'hFFFF, 1'b0, 6'd0, ST_DRAWN);
      add_item(MODE_RETURN, 6'd63, 16'd0, 1'b1, 6'd0, ST_ACCEPTED);
      add_item(MODE_RETURN, 6'd0, 16'hFFFF, 1'b1, 6'd0, ST_ACCEPTED);
      add_item(MODE_RETURN, 6'd7, 16'd0, 1'b1, 6'd0, ST_FULL);
      // zero total: draws empty, returns full
      add_cfg(7'd0);
      add_item(MODE_DRAW, 6'd0, 16'hFFFF, 1'b1, 6'd0, ST_EMPTY);
      add_item(MODE_RETURN, 6'd63, 16'd0, 1'b1, 6'd0, ST_FULL);
      // one ID: drain, return an out-of-range ID, refill and draw it back
      add_cfg(7'd1);
      add_item(MODE_DRAW, 6'd0, 16'hFFFF, 1'b1, 6'd0, ST_DRAWN);
      add_item(MODE_DRAW, 6'd0, 16'd0, 1'b1, 6'd0, ST_EMPTY);
      add_item(MODE_RETURN, 6'd42, 16'd0, 1'b1, 6'd0, ST_ACCEPTED);
      add_item(MODE_RETURN, 6'd3, 16'd0, 1'b1, 6'd0, ST_FULL);
      add_item(MODE_DRAW, 6'd0, 16'd12345, 1'b1, 6'd42, ST_DRAWN);
      // two IDs: duplicate returns are kept, refill in pile order
      add_cfg(7'd2);
      add_item(MODE_DRAW, 6'd0, 16'd1, 1'b1, 6'd1, ST_DRAWN);
      add_item(MODE_DRAW, 6'd0, 16'd0, 1'b1, 6'd0, ST_DRAWN);
      add_item(MODE_RETURN, 6'd9, 16'd0, 1'b1, 6'd0, ST_ACCEPTED);
      add_item(MODE_RETURN, 6'd9, 16'd0, 1'b1, 6'd0, ST_ACCEPTED);
      add_item(MODE_RETURN, 6'd0, 16'd0, 1'b1, 6'd0, ST_FULL);
      add_item(MODE_DRAW, 6'd0, 16'hFFFF, 1'b1, 6'd9, ST_DRAWN);
      // total above range saturates to the full pool
      add_cfg(7'd127);
      add_item(MODE_RETURN, 6'd1, 16'd0, 1'b1, 6'd0, ST_FULL);
      add_item(MODE_DRAW, 6'd0, 16'h8000, 1'b1, 6'd0, ST_DRAWN);
      add_item(MODE_DRAW, 6'd21, 16'hFFFF, 1'b0, 6'd0, ST_DRAWN);
      add_item(MODE_RETURN, 6'd63, 16'd0, 1'b1, 6'd0, ST_ACCEPTED);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CFG) begin
            write_total(row.total);
         end else begin
            send_item(row.mode, row.card, row.rnd, row.typed, row.want);
         end
      end

      // random phases: mostly small pools, a draw/return mix per phase
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: total = 7'd0;
            1: total = 7'd1;
            2: total = 7'd64;
            3: total = 7'($urandom_range(65, 127));
            default: total = 7'($urandom_range(2, 20));
         endcase
         write_total(total);
         n = (total == 0) ? $urandom_range(5, 15) : $urandom_range(60, 140);
         draw_pct = $urandom_range(35, 70);
         repeat (n) begin
            mode = ($urandom_range(1, 100) <= draw_pct) ? MODE_DRAW : MODE_RETURN;
            send_item(mode, ID_W'($urandom_range(0, 63)), RND_W'($urandom_range(0, 65535)),
                      1'b0, '0);
            items_sent++;
         end
      end

      // drain outstanding results, then allow for a stray one
      release_valid();
      while (pool_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Receiver stall pattern: stretches of no stall, random stall, held stall
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 2);
         stall_left <= $urandom_range(1, 64);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= 1'b1;
      endcase
   end

   // Compare each result transfer with the oldest pending answer
   always @(posedge clock) begin : check_results
      pool_result_type want;
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pool_answers.size() == 0) begin
            report("unrequested result status", int'(rsp_status), -1);
         end else begin
            want = pool_answers.pop_front();
            if (rsp_card_out !== want.card) begin
               report("card_out", int'(rsp_card_out), int'(want.card));
            end
            if (rsp_status !== want.status) begin
               report("status", int'(rsp_status), int'(want.status));
            end
         end
      end
   end

   // Hard stop on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

endmodule

`default_nettype wire
